/* hdl/adc_decimate_deadband_average_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the decimating dead-band averaging filter
// Concurrent checks that can be compiled out by defining ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef ADC_DECIMATE_DEADBAND_AVERAGE_ASSERT_SVH
`define ADC_DECIMATE_DEADBAND_AVERAGE_ASSERT_SVH
`ifndef ASSERT_OFF
// Property that must hold in the same cycle as its trigger.
`define ADDA_ASSERT_NOW(lbl, clk, rst_n, trig, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
        else $error(msg);
// Property that must hold in the cycle after its trigger.
`define ADDA_ASSERT_NEXT(lbl, clk, rst_n, trig, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);
`else
`define ADDA_ASSERT_NOW(lbl, clk, rst_n, trig, prop, msg)
`define ADDA_ASSERT_NEXT(lbl, clk, rst_n, trig, prop, msg)
`endif
`endif

/* hdl/adda_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adda_pkg
// Shared constants, register codes and configuration type of the filter.
// ----------------------------------------------------------------------------
package adda_pkg;

    // Default sizes of the filter.
    localparam int unsigned SAMPLE_BITS_DEF = 12;
    localparam int unsigned INNER_COUNT_DEF = 16;
    localparam int unsigned OUTER_COUNT_DEF = 16;
    localparam int unsigned WINDOW_DEF      = 4;

    // Register and display widths.
    localparam int unsigned THR_W         = 12;
    localparam int unsigned SCALE_W       = 10;
    localparam int unsigned DISP_W        = 10;
    localparam int unsigned DISPLAY_SHIFT = 12;

    localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(10);
    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(240);
    localparam logic [DISP_W-1:0]  DISP_MAX    = DISP_W'(1023);

    // Configuration port.
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 3;

    // Depth of the request queue between front and back.
    localparam int unsigned QUEUE_DEPTH = 2;

    // Register indexes on the configuration port.
    typedef enum logic {
        REG_JUMP_THRESHOLD = 1'b0,
        REG_SCALE_FACTOR   = 1'b1
    } t_reg_idx;

    // Configuration handed to the filter back end.
    typedef struct packed {
        logic [THR_W-1:0]   jump_threshold;
        logic [SCALE_W-1:0] scale_factor;
    } t_cfg;

endpackage

/* hdl/adda_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adda_front
// Two-level decimator: accumulates samples and issues filter requests.
// ----------------------------------------------------------------------------
module adda_front
    import adda_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int unsigned INNER_COUNT = INNER_COUNT_DEF,
    parameter int unsigned OUTER_COUNT = OUTER_COUNT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_prime,
    input  logic                   i_display_hold,
    output logic                   o_push,
    output logic [SAMPLE_BITS-1:0] o_push_value,
    output logic                   o_push_show
);

    localparam int unsigned ILOG = $clog2(INNER_COUNT);
    localparam int unsigned OLOG = $clog2(OUTER_COUNT);
    localparam int unsigned IS_W = SAMPLE_BITS + ILOG;
    localparam int unsigned OS_W = SAMPLE_BITS + OLOG;

    logic [IS_W-1:0]        r_inner_sum;
    logic [ILOG-1:0]        r_inner_cnt;
    logic [OS_W-1:0]        r_outer_sum;
    logic [OLOG-1:0]        r_outer_cnt;

    logic [IS_W-1:0]        n_inner_sum;
    logic [OS_W-1:0]        n_outer_sum;
    logic [SAMPLE_BITS-1:0] inner_mean;
    logic [SAMPLE_BITS-1:0] outer_mean;
    logic                   inner_done;
    logic                   outer_done;
    logic                   decim;

    // Running sums including the current sample; means are plain shifts.
    assign n_inner_sum = r_inner_sum + IS_W'(i_sample);
    assign inner_mean  = n_inner_sum[IS_W-1 -: SAMPLE_BITS];
    assign n_outer_sum = r_outer_sum + OS_W'(inner_mean);
    assign outer_mean  = n_outer_sum[OS_W-1 -: SAMPLE_BITS];
    assign inner_done  = (r_inner_cnt == ILOG'(INNER_COUNT - 1));
    assign outer_done  = (r_outer_cnt == OLOG'(OUTER_COUNT - 1));
    assign decim       = !i_prime && inner_done && outer_done;

    // A prime sample or a completed outer group makes a filter request.
    assign o_push       = i_accept && (i_prime || decim);
    assign o_push_value = i_prime ? i_sample : outer_mean;
    assign o_push_show  = !i_prime && !i_display_hold;

    // Accumulators; prime samples leave them untouched.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner_sum <= '0;
            r_inner_cnt <= '0;
            r_outer_sum <= '0;
            r_outer_cnt <= '0;
        end else if (i_accept && !i_prime) begin
            if (inner_done) begin
                r_inner_sum <= '0;
                r_inner_cnt <= '0;
                if (outer_done) begin
                    r_outer_sum <= '0;
                    r_outer_cnt <= '0;
                end else begin
                    r_outer_sum <= n_outer_sum;
                    r_outer_cnt <= r_outer_cnt + OLOG'(1);
                end
            end else begin
                r_inner_sum <= n_inner_sum;
                r_inner_cnt <= r_inner_cnt + ILOG'(1);
            end
        end
    end

endmodule

/* hdl/adda_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adda_queue
// Short register queue that decouples the decimator from the filter.
// ----------------------------------------------------------------------------
module adda_queue
    import adda_pkg::*;
#(
    parameter int unsigned DATA_W = SAMPLE_BITS_DEF + 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_push_data,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_head
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

/* hdl/adda_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adda_back
// Dead-band ring filter, display scaling and the output register.
// ----------------------------------------------------------------------------
`include "adc_decimate_deadband_average_assert.svh"
module adda_back
    import adda_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int unsigned WINDOW      = WINDOW_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_req_valid,
    input  logic [SAMPLE_BITS-1:0] i_req_value,
    input  logic                   i_req_show,
    output logic                   o_req_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [SAMPLE_BITS-1:0] o_filtered,
    output logic [DISP_W-1:0]      o_display_value,
    output logic                   o_display_valid
);

    localparam int unsigned WLOG   = $clog2(WINDOW);
    localparam int unsigned SUM_W  = SAMPLE_BITS + WLOG;
    localparam int unsigned CMP_W  = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
    localparam int unsigned PROD_W = SAMPLE_BITS + SCALE_W;
    localparam int unsigned SHR_W  = PROD_W - DISPLAY_SHIFT;
    localparam int unsigned EXT_W  = ((SHR_W > DISP_W) ? SHR_W : DISP_W) + 1;

    // Filter state.
    logic [SAMPLE_BITS-1:0] r_ring [WINDOW];
    logic [WLOG-1:0]        r_ptr;
    logic [SUM_W-1:0]       r_sum;
    logic [SAMPLE_BITS-1:0] r_prev;

    // Pipeline registers.
    logic                   r_a_valid;
    logic [SAMPLE_BITS-1:0] r_a_filt;
    logic                   r_a_show;
    logic                   r_b_valid;
    logic [SAMPLE_BITS-1:0] r_b_filt;
    logic                   r_b_show;
    logic [PROD_W-1:0]      r_b_prod;
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_filt;
    logic [DISP_W-1:0]      r_out_disp;
    logic                   r_out_show;

    logic [SAMPLE_BITS-1:0] diff;
    logic                   jump;
    logic [SAMPLE_BITS-1:0] kept;
    logic [SUM_W-1:0]       n_sum;
    logic [PROD_W-1:0]      n_b_prod;
    logic [SHR_W-1:0]       shifted;
    logic [EXT_W-1:0]       shifted_ext;
    logic [DISP_W-1:0]      n_out_disp;
    logic                   out_ready;
    logic                   b_ready;
    logic                   a_ready;
    logic                   pop;

    // Stall chain from the output back to the queue.
    assign out_ready = !r_out_valid || !i_out_stall;
    assign b_ready   = !r_b_valid || out_ready;
    assign a_ready   = !r_a_valid || b_ready;
    assign pop       = i_req_valid && a_ready;
    assign o_req_pop = pop;

    // Dead band: keep the old raw value unless the jump exceeds the threshold.
    assign diff  = (i_req_value >= r_prev) ? (i_req_value - r_prev) : (r_prev - i_req_value);
    assign jump  = CMP_W'(diff) > CMP_W'(i_cfg.jump_threshold);
    assign kept  = jump ? i_req_value : r_prev;
    // The ring sum is kept running: drop the overwritten entry, add the new one.
    assign n_sum = r_sum - SUM_W'(r_ring[r_ptr]) + SUM_W'(kept);

    // Ring, running sum and previous raw value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW; k++) begin
                r_ring[k] <= '0;
            end
            r_ptr  <= '0;
            r_sum  <= '0;
            r_prev <= '0;
        end else if (pop) begin
            r_ring[r_ptr] <= kept;
            r_ptr         <= r_ptr + WLOG'(1);
            r_sum         <= n_sum;
            r_prev        <= i_req_value;
        end
    end

    // Stage A: ring mean.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_a_filt <= n_sum[SUM_W-1 -: SAMPLE_BITS];
            r_a_show <= i_req_show;
        end
    end

    // Stage B: display product.
    assign n_b_prod = PROD_W'(r_a_filt) * PROD_W'(i_cfg.scale_factor);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_ready && r_a_valid) begin
            r_b_filt <= r_a_filt;
            r_b_show <= r_a_show;
            r_b_prod <= n_b_prod;
        end
    end

    // Shift and saturate the display value; zero when not shown.
    assign shifted     = r_b_prod[PROD_W-1 -: SHR_W];
    assign shifted_ext = EXT_W'(shifted);
    always_comb begin
        if (!r_b_show) begin
            n_out_disp = '0;
        end else if (shifted_ext > EXT_W'(DISP_MAX)) begin
            n_out_disp = DISP_MAX;
        end else begin
            n_out_disp = shifted_ext[DISP_W-1:0];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_b_valid) begin
            r_out_filt <= r_b_filt;
            r_out_disp <= n_out_disp;
            r_out_show <= r_b_show;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_filtered      = r_out_filt;
    assign o_display_value = r_out_disp;
    assign o_display_valid = r_out_show;

    // Each filter update moves the ring pointer by exactly one entry.
    `ADDA_ASSERT_NEXT(a_ptr_step, i_clk, i_rst_n, pop, (r_ptr - $past(r_ptr)) == WLOG'(1), "ring pointer did not advance by one")
    // A held stage A keeps its request.
    `ADDA_ASSERT_NEXT(a_stage_a_hold, i_clk, i_rst_n, r_a_valid && !b_ready, r_a_valid && $stable(r_a_filt), "stage A request lost while held")
    // A held stage B keeps its product.
    `ADDA_ASSERT_NEXT(a_stage_b_hold, i_clk, i_rst_n, r_b_valid && !out_ready, r_b_valid && $stable(r_b_prod), "stage B product lost while held")
    // No request is taken while the pipeline is full and stalled.
    `ADDA_ASSERT_NOW(a_no_pop_full, i_clk, i_rst_n, r_a_valid && r_b_valid && r_out_valid && i_out_stall, !pop, "request taken into a full pipeline")

endmodule

/* hdl/adc_decimate_deadband_average.sv */
`timescale 1ns / 1ps
// A request that produces a result passes through the queue, stage A, stage B and the output register.
// Throughput: one sample per cycle unless stalled; a result leaves every 256th plain sample and
// every prime sample. The rate is set by the ring update in the back end, fed through a 2-entry
// queue; the input stalls only while that queue is full, after the result side has held off.
// Reset: synchronous active-low; clears accumulators, ring, pointers and queue, and loads
// jump_threshold to 10 and scale_factor to 240. No clearing pass is needed.
// ----------------------------------------------------------------------------
// adc_decimate_deadband_average
// Decimating dead-band moving-average filter with a scaled display value.
// ----------------------------------------------------------------------------
module adc_decimate_deadband_average
    import adda_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int unsigned INNER_COUNT = INNER_COUNT_DEF,
    parameter int unsigned OUTER_COUNT = OUTER_COUNT_DEF,
    parameter int unsigned WINDOW      = WINDOW_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Sample channel
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_prime,
    input  logic                   i_display_hold,
    // Result channel
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [SAMPLE_BITS-1:0] o_filtered,
    output logic [DISP_W-1:0]      o_display_value,
    output logic                   o_display_valid,
    // Configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int unsigned Q_W = SAMPLE_BITS + 1;

    t_cfg                   r_cfg;
    t_reg_idx               reg_idx;
    logic                   cfg_wr;
    logic                   accept;
    logic                   push;
    logic [SAMPLE_BITS-1:0] push_value;
    logic                   push_show;
    logic                   q_full;
    logic                   q_valid;
    logic [Q_W-1:0]         q_head;
    logic                   q_pop;

    // Configuration registers.
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.jump_threshold <= THR_RESET;
            r_cfg.scale_factor   <= SCALE_RESET;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_JUMP_THRESHOLD: r_cfg.jump_threshold <= pwdata[THR_W-1:0];
                REG_SCALE_FACTOR:   r_cfg.scale_factor   <= pwdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (reg_idx)
            REG_JUMP_THRESHOLD: prdata = APB_DATA_W'(r_cfg.jump_threshold);
            REG_SCALE_FACTOR:   prdata = APB_DATA_W'(r_cfg.scale_factor);
            default:            prdata = '0;
        endcase
    end

    // Sample request handshake.
    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !o_in_stall;

    adda_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .INNER_COUNT (INNER_COUNT),
        .OUTER_COUNT (OUTER_COUNT)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_sample       (i_sample),
        .i_prime        (i_prime),
        .i_display_hold (i_display_hold),
        .o_push         (push),
        .o_push_value   (push_value),
        .o_push_show    (push_show)
    );

    adda_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data ({push_show, push_value}),
        .i_pop       (q_pop),
        .o_full      (q_full),
        .o_valid     (q_valid),
        .o_head      (q_head)
    );

    adda_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .WINDOW      (WINDOW)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_req_valid     (q_valid),
        .i_req_value     (q_head[SAMPLE_BITS-1:0]),
        .i_req_show      (q_head[SAMPLE_BITS]),
        .o_req_pop       (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_filtered      (o_filtered),
        .o_display_value (o_display_value),
        .o_display_valid (o_display_valid)
    );

endmodule
